// ===== rtl/isws_pkg.sv =====
// Shared constants, types and helper functions of the indexed word stack.
package isws_pkg;

	localparam int DEPTH  = 64;
	localparam int WIDTH  = 32;
	localparam int ACT_W  = 3;
	localparam int POS_W  = 6;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int FILL_W = 7;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int GRP    = 32;
	localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

	typedef logic [WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CMP_W-1:0] cmp_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH   = 3'd0,
		ACT_POP    = 3'd1,
		ACT_READ   = 3'd2,
		ACT_WRITE  = 3'd3,
		ACT_REMOVE = 3'd4
	} act_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} stat_t;

	// Command broadcast to every cell of the row
	typedef struct packed {
		logic  load;
		logic  shift;
		logic  tap;
		cmp_t  target;
		word_t data;
	} cell_cmd_t;

	function automatic word_t to_word(input logic [DATA_W-1:0] d);
		logic [WIDTH+DATA_W-1:0] t;
		t = {{WIDTH{1'b0}}, d};
		return t[WIDTH-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] from_word(input word_t w);
		logic [WIDTH+DATA_W-1:0] t;
		t = {{DATA_W{1'b0}}, w};
		return t[DATA_W-1:0];
	endfunction

	function automatic logic [FILL_W-1:0] to_fill(input cnt_t c);
		logic [CNT_W+FILL_W-1:0] t;
		t = {{FILL_W{1'b0}}, c};
		return t[FILL_W-1:0];
	endfunction

	function automatic cmp_t cnt_to_cmp(input cnt_t c);
		logic [CNT_W+CMP_W-1:0] t;
		t = {{CMP_W{1'b0}}, c};
		return t[CMP_W-1:0];
	endfunction

	function automatic cmp_t pos_to_cmp(input logic [POS_W-1:0] p);
		logic [POS_W+CMP_W-1:0] t;
		t = {{CMP_W{1'b0}}, p};
		return t[CMP_W-1:0];
	endfunction

endpackage

// ===== rtl/isws_if.sv =====
// Request and response channel interfaces of the indexed word stack.
interface isws_in_if import isws_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [POS_W-1:0]  position;
	logic [DATA_W-1:0] data_in;

	modport source (output valid, action, position, data_in, input ready);
	modport sink (input valid, action, position, data_in, output ready);
endinterface

interface isws_out_if import isws_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_value;
	logic [STAT_W-1:0] status;
	logic [FILL_W-1:0] fill_count;

	modport source (output valid, read_value, status, fill_count, input ready);
	modport sink (input valid, read_value, status, fill_count, output ready);
endinterface

// ===== rtl/isws_cell.sv =====
// One storage cell of the word row: load, shift from the upper neighbour, tap.
module isws_cell import isws_pkg::*; (
	input  logic      clk,
	input  cmp_t      idx,
	input  cell_cmd_t cmd,
	input  word_t     nxt,
	output word_t     word,
	output word_t     tap
);

	word_t word_q;
	logic  hit;
	logic  above;

	assign hit   = (idx == cmd.target);
	assign above = (idx > cmd.target);

	always_ff @(posedge clk) begin
		if (cmd.load && hit) begin
			word_q <= cmd.data;
		end else if (cmd.shift && (hit || above)) begin
			word_q <= nxt;
		end
	end

	assign word = word_q;
	// drive the old word so that remove returns it before the shift lands
	assign tap  = (cmd.tap && hit) ? word_q : '0;

endmodule

// ===== rtl/isws_gather.sv =====
// Registered OR tree that collects the single tapped word from the cell row.
module isws_gather import isws_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t taps [NGRP*GRP],
	output word_t result
);

	word_t grp_c  [NGRP];
	word_t grp_s1 [NGRP];

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_c[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				grp_c[g] = grp_c[g] | taps[g*GRP + k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_s1 <= grp_c;
		end
	end

	always_comb begin
		result = '0;
		for (int g = 0; g < NGRP; g++) begin
			result = result | grp_s1[g];
		end
	end

endmodule

// ===== rtl/indexed_stack_with_removal.sv =====
// Indexed word stack: a row of word cells with push, pop, read, write and remove.
// Requests are taken one at a time: the next request waits until the
// previous one has passed the registered OR tree into the output register.
// Reset clears the fill count and all valid flags; cell contents are not reset.
module indexed_stack_with_removal import isws_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	isws_in_if.sink    req,
	isws_out_if.source rsp
);

	cnt_t      count_q;
	logic      exec_q;
	logic      gath_q;
	logic      out_valid_q;
	cell_cmd_t cmd_q;
	cell_cmd_t cmd_d;
	cell_cmd_t cell_cmd;
	stat_t     st_q;
	stat_t     st_d;
	cnt_t      cnt_d;
	cnt_t      fill_q;
	cmp_t      pos_c;
	cmp_t      cnt_c;
	logic      in_range;
	logic      accept;
	logic      move_out;
	word_t     gather_word;
	logic [DATA_W-1:0] rd_q;
	stat_t             ost_q;
	logic [FILL_W-1:0] ofill_q;

	word_t words [DEPTH];
	word_t taps  [NGRP*GRP];

	assign req.ready = !exec_q && !gath_q;
	assign accept    = req.valid && req.ready;
	assign move_out  = gath_q && (!out_valid_q || rsp.ready);

	assign pos_c    = pos_to_cmp(req.position);
	assign cnt_c    = cnt_to_cmp(count_q);
	assign in_range = (pos_c < cnt_c);

	// decide status, new count and cell command at the request beat
	always_comb begin
		cmd_d        = '0;
		cmd_d.data   = to_word(req.data_in);
		cmd_d.target = pos_c;
		st_d         = ST_OK;
		cnt_d        = count_q;
		case (act_t'(req.action))
			ACT_PUSH: begin
				if (count_q == CNT_W'(DEPTH)) begin
					st_d = ST_FULL;
				end else begin
					cmd_d.load   = 1'b1;
					cmd_d.target = cnt_c;
					cnt_d        = count_q + 1'b1;
				end
			end
			ACT_POP: begin
				if (count_q == '0) begin
					st_d = ST_EMPTY;
				end else begin
					cmd_d.tap    = 1'b1;
					cmd_d.target = cnt_c - 1'b1;
					cnt_d        = count_q - 1'b1;
				end
			end
			ACT_READ: begin
				if (!in_range) begin
					st_d = ST_RANGE;
				end else begin
					cmd_d.tap = 1'b1;
				end
			end
			ACT_WRITE: begin
				if (!in_range) begin
					st_d = ST_RANGE;
				end else begin
					cmd_d.load = 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (!in_range) begin
					st_d = ST_RANGE;
				end else begin
					cmd_d.tap   = 1'b1;
					cmd_d.shift = 1'b1;
					cnt_d       = count_q - 1'b1;
				end
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			exec_q      <= 1'b0;
			gath_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= cnt_d;
			end
			exec_q <= accept;
			if (exec_q) begin
				gath_q <= 1'b1;
			end else if (move_out) begin
				gath_q <= 1'b0;
			end
			if (move_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_d;
			st_q   <= st_d;
			fill_q <= cnt_d;
		end
		if (move_out) begin
			rd_q    <= from_word(gather_word);
			ost_q   <= st_q;
			ofill_q <= to_fill(fill_q);
		end
	end

	// act on the row only in the cycle after the beat
	always_comb begin
		cell_cmd       = cmd_q;
		cell_cmd.load  = cmd_q.load && exec_q;
		cell_cmd.shift = cmd_q.shift && exec_q;
		cell_cmd.tap   = cmd_q.tap && exec_q;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t nxt;
		if (i == DEPTH - 1) begin : g_top
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = words[i+1];
		end
		isws_cell u_cell (
			.clk  (clk),
			.idx  (CMP_W'(i)),
			.cmd  (cell_cmd),
			.nxt  (nxt),
			.word (words[i]),
			.tap  (taps[i])
		);
	end

	for (genvar j = DEPTH; j < NGRP*GRP; j++) begin : g_pad
		assign taps[j] = '0;
	end

	isws_gather u_gather (
		.clk    (clk),
		.en     (exec_q),
		.taps   (taps),
		.result (gather_word)
	);

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = rd_q;
	assign rsp.status     = ost_q;
	assign rsp.fill_count = ofill_q;

endmodule

// ===== rtl/isws_chk.sv =====
// Port-level checker of the indexed word stack, bound to the top level.
module isws_chk import isws_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] read_value,
	input logic [STAT_W-1:0] status,
	input logic [FILL_W-1:0] fill_count
);

	// a response beat that waits must hold its read value and status
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status))
		else $error("stalled response changed");

	// one request at a time: no beat right after a beat
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> int'(fill_count) == DEPTH && read_value == '0)
		else $error("full status with wrong count");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> fill_count == '0 && read_value == '0)
		else $error("empty status with data or count");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(fill_count) <= DEPTH &&
			(status != ST_RANGE || read_value == '0))
		else $error("count beyond depth or data on range error");

endmodule

bind indexed_stack_with_removal isws_chk u_isws_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.read_value (rsp.read_value),
	.status     (rsp.status),
	.fill_count (rsp.fill_count)
);

// ===== tb/sv/isws_result_checker.sv =====
`timescale 1ns / 100ps
// Reply checker of the indexed word stack: shadow stack, queue of owed replies, field compare.
module isws_result_checker import isws_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	isws_in_if   req,
	isws_out_if  rsp,
	output int   errors,
	output int   replies_due,
	output int   words_held,
	output int   replies_seen,
	output int   refusals,
	output int   peak_fill
);

	typedef struct packed {
		logic [DATA_W-1:0] value;
		stat_t             status;
		logic [FILL_W-1:0] fill;
	} stack_reply_t;

	word_t        shadow_words [DEPTH];
	int           shadow_fill;
	stack_reply_t owed_replies [$];

	// Apply one request to the shadow stack and return the reply it owes
	function automatic stack_reply_t stack_apply(input logic [ACT_W-1:0] action,
		input logic [POS_W-1:0] position, input logic [DATA_W-1:0] data);
		stack_reply_t r;
		int           p;
		p        = int'(position);
		r.value  = '0;
		r.status = ST_OK;
		case (action)
		ACT_PUSH: begin
			if (shadow_fill >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				shadow_words[shadow_fill] = word_t'(data);
				shadow_fill++;
			end
		end
		ACT_POP: begin
			if (shadow_fill == 0) begin
				r.status = ST_EMPTY;
			end else begin
				shadow_fill--;
				r.value = DATA_W'(shadow_words[shadow_fill]);
			end
		end
		ACT_READ: begin
			if (p >= shadow_fill) r.status = ST_RANGE;
			else r.value = DATA_W'(shadow_words[p]);
		end
		ACT_WRITE: begin
			if (p >= shadow_fill) r.status = ST_RANGE;
			else shadow_words[p] = word_t'(data);
		end
		ACT_REMOVE: begin
			if (p >= shadow_fill) begin
				r.status = ST_RANGE;
			end else begin
				r.value = DATA_W'(shadow_words[p]);
				// close the gap: every later word moves down one place
				for (int i = p; i + 1 < shadow_fill; i++)
					shadow_words[i] = shadow_words[i + 1];
				shadow_fill--;
			end
		end
		default: ; // spare codes leave the stack alone
		endcase
		r.fill = FILL_W'(shadow_fill);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stack_reply_t want;
		if (!arst_n) begin
			shadow_fill = 0;
			owed_replies.delete();
		end else begin
			// check the reply beat first: it never belongs to a request of this edge
			if (rsp.valid && rsp.ready) begin
				replies_seen++;
				if (owed_replies.size() == 0) begin
					errors++;
					$error("unexpected reply beat: read_value %h status %0d fill_count %0d",
						rsp.read_value, rsp.status, rsp.fill_count);
				end else begin
					want = owed_replies.pop_front();
					if (rsp.read_value !== want.value) begin
						errors++;
						$error("read_value: expected %h, got %h", want.value, rsp.read_value);
					end
					if (rsp.status !== want.status) begin
						errors++;
						$error("status: expected %0d, got %0d", want.status, rsp.status);
					end
					if (rsp.fill_count !== want.fill) begin
						errors++;
						$error("fill_count: expected %0d, got %0d", want.fill, rsp.fill_count);
					end
				end
			end
			if (req.valid && req.ready) begin
				want = stack_apply(req.action, req.position, req.data_in);
				if (want.status != ST_OK) refusals++;
				owed_replies.push_back(want);
			end
		end
		if (shadow_fill > peak_fill) peak_fill = shadow_fill;
		replies_due = owed_replies.size();
		words_held  = shadow_fill;
	end

endmodule

// ===== tb/sv/tb_indexed_stack_with_removal.sv =====
`timescale 1ns / 100ps
// Top of the indexed word stack testbench: clock, reset, request and reply traffic, verdict.
module tb_indexed_stack_with_removal;
	import isws_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int ITEMS       = 1400;
	localparam int IDLE_PCT    = 25;
	localparam int STALL_LIMIT = 1000;
	localparam int TAIL_CYCLES = 8;

	localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;

	typedef enum int {TR_MIXED, TR_FILL, TR_DRAIN} traffic_t;

	logic clk;
	logic arst_n;
	logic idle_on;
	int   errors;
	int   replies_due;
	int   words_held;
	int   replies_seen;
	int   refusals;
	int   peak_fill;
	int   sent;
	int   quiet_cycles;

	isws_in_if  req_if ();
	isws_out_if rsp_if ();

	indexed_stack_with_removal u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	isws_result_checker u_replies (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_if),
		.rsp          (rsp_if),
		.errors       (errors),
		.replies_due  (replies_due),
		.words_held   (words_held),
		.replies_seen (replies_seen),
		.refusals     (refusals),
		.peak_fill    (peak_fill)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	always @(negedge clk) begin
		rsp_if.ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("tb_indexed_stack_with_removal: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat
	task automatic send_beat(input logic [ACT_W-1:0] a, input logic [POS_W-1:0] p,
		input logic [DATA_W-1:0] d);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid    <= 1'b1;
		req_if.action   <= a;
		req_if.position <= p;
		req_if.data_in  <= d;
		do @(posedge clk); while (!(req_if.valid && req_if.ready));
		sent++;
		@(negedge clk);
	endtask

	// Hold the request side until every owed reply has arrived
	task automatic hold_until_drained();
		req_if.valid <= 1'b0;
		do @(negedge clk); while (replies_due != 0);
	endtask

	function automatic logic [ACT_W-1:0] pick_action();
		if ($urandom_range(0, 99) < 3)
			return ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
		return ACT_W'($urandom_range(ACT_PUSH, ACT_REMOVE));
	endfunction

	// Mostly a position in use, now and then anywhere
	function automatic logic [POS_W-1:0] pick_position();
		if (words_held > 0 && $urandom_range(0, 9) < 8)
			return POS_W'($urandom_range(0, words_held - 1));
		return POS_W'($urandom_range(0, DEPTH - 1));
	endfunction

	function automatic logic [DATA_W-1:0] pick_word();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return '0;
		if (roll == 1) return '1;
		return DATA_W'($urandom);
	endfunction

	task automatic random_beat(input traffic_t mode);
		int               roll;
		logic [ACT_W-1:0] a;
		roll = $urandom_range(0, 99);
		case (mode)
		TR_FILL:  a = (roll < 70) ? ACT_W'(ACT_PUSH) : pick_action();
		TR_DRAIN: begin
			if (roll < 35) a = ACT_POP;
			else if (roll < 70) a = ACT_REMOVE;
			else a = pick_action();
		end
		default:  a = pick_action();
		endcase
		send_beat(a, pick_position(), pick_word());
	endtask

	initial begin
		traffic_t mode;
		int       seg_len;
		arst_n          = 1'b0;
		idle_on         = 1'b1;
		req_if.valid    = 1'b0;
		req_if.action   = '0;
		req_if.position = '0;
		req_if.data_in  = '0;
		rsp_if.ready    = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty store: pop, read, write and remove are refused, spare codes are not; then pushes fill it
		send_beat(ACT_POP, '0, '0);
		send_beat(ACT_READ, '0, '0);
		send_beat(ACT_WRITE, '0, 32'hDEADBEEF);
		send_beat(ACT_REMOVE, '0, '0);
		send_beat(ACT_SPARE_FIRST, '0, '1);
		send_beat(ACT_SPARE_LAST, POS_W'(DEPTH - 1), '1);
		send_beat(ACT_PUSH, '0, '0);
		send_beat(ACT_PUSH, '0, '1);
		send_beat(ACT_PUSH, '0, 32'hA5A5A5A5);
		send_beat(ACT_PUSH, '0, 32'h12345678);
		send_beat(ACT_READ, '0, '0);
		send_beat(ACT_READ, 6'd3, '0);
		send_beat(ACT_READ, 6'd4, '0);
		send_beat(ACT_READ, POS_W'(DEPTH - 1), '0);
		send_beat(ACT_WRITE, 6'd1, 32'h5A5A5A5A);
		send_beat(ACT_READ, 6'd1, '0);
		send_beat(ACT_WRITE, 6'd4, '1);
		// remove at the bottom shifts the rest down
		send_beat(ACT_REMOVE, '0, '0);
		send_beat(ACT_READ, '0, '0);
		send_beat(ACT_REMOVE, 6'd2, '0);
		send_beat(ACT_REMOVE, 6'd7, '0);
		send_beat(ACT_POP, '0, '0);
		send_beat(ACT_POP, '0, '0);
		send_beat(ACT_POP, '0, '0);
		hold_until_drained();

		while (sent < ITEMS) begin
			mode    = traffic_t'($urandom_range(TR_MIXED, TR_DRAIN));
			seg_len = $urandom_range(40, 120);
			idle_on <= !(sent >= 500 && sent < 800);
			repeat (seg_len) random_beat(mode);
			if ($urandom_range(0, 3) == 0) hold_until_drained();
		end
		req_if.valid <= 1'b0;
		while (replies_due != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d requests sent, %0d replies checked, %0d refused", sent,
			replies_seen, refusals);
		$display("run: stack filled to %0d of %0d words at its peak", peak_fill, DEPTH);
		if (errors == 0) begin
			$display("tb_indexed_stack_with_removal: done, clean");
		end else begin
			$display("tb_indexed_stack_with_removal: done, errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/isws_pkg.sv
rtl/isws_if.sv
rtl/isws_cell.sv
rtl/isws_gather.sv
rtl/indexed_stack_with_removal.sv
rtl/isws_chk.sv
tb/sv/isws_result_checker.sv
tb/sv/tb_indexed_stack_with_removal.sv
